FILE: rtl/spag_pkg.sv
// Package for the sine plasma attribute generator.
// Holds the sine table, phase gains, register indexes and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spag_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 28;
   localparam int unsigned PHASE_COUNT     = 6;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROW_COUNT     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INK_PALETTE   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PAPER_PALETTE = 2'd2;

   localparam logic [5:0]  ROW_COUNT_RESET     = 6'd25;
   localparam logic [27:0] INK_PALETTE_RESET   = 28'd4584224;
   localparam logic [27:0] PAPER_PALETTE_RESET = 28'd2031040;

   localparam logic KIND_PIXEL   = 1'b0;
   localparam logic KIND_ADVANCE = 1'b1;

   localparam logic [7:0] PALETTE_STEP = 8'd37;

   // per-accumulator phase gain, order 1A,1B,2A,2B,3A,3B
   localparam logic [4:0] PHASE_GAIN [PHASE_COUNT] = '{
      5'd8, 5'd16, 5'd8, 5'd16, 5'd6, 5'd12
   };

   // fixed drift increments for the even accumulators
   localparam logic [7:0] DRIFT_STEP_1A = 8'd3;
   localparam logic [7:0] DRIFT_STEP_2A = 8'd5;
   localparam logic [7:0] DRIFT_STEP_3A = 8'd2;

   typedef struct packed {
      logic [7:0] p1a;
      logic [7:0] p1b;
      logic [7:0] p2a;
      logic [7:0] p2b;
      logic [7:0] p3a;
      logic [7:0] p3b;
   } phase_view_type;

   localparam logic [7:0] SINE_LUT [256] = '{
      8'd128,8'd131,8'd134,8'd137,8'd140,8'd144,8'd147,8'd150,
      8'd153,8'd156,8'd159,8'd162,8'd165,8'd168,8'd171,8'd174,
      8'd177,8'd179,8'd182,8'd185,8'd188,8'd191,8'd193,8'd196,
      8'd199,8'd201,8'd204,8'd206,8'd209,8'd211,8'd213,8'd216,
      8'd218,8'd220,8'd222,8'd224,8'd226,8'd228,8'd230,8'd232,
      8'd234,8'd235,8'd237,8'd239,8'd240,8'd241,8'd243,8'd244,
      8'd245,8'd246,8'd248,8'd249,8'd250,8'd250,8'd251,8'd252,
      8'd253,8'd253,8'd254,8'd254,8'd254,8'd255,8'd255,8'd255,
      8'd255,8'd255,8'd255,8'd255,8'd254,8'd254,8'd254,8'd253,
      8'd253,8'd252,8'd251,8'd250,8'd250,8'd249,8'd248,8'd246,
      8'd245,8'd244,8'd243,8'd241,8'd240,8'd239,8'd237,8'd235,
      8'd234,8'd232,8'd230,8'd228,8'd226,8'd224,8'd222,8'd220,
      8'd218,8'd216,8'd213,8'd211,8'd209,8'd206,8'd204,8'd201,
      8'd199,8'd196,8'd193,8'd191,8'd188,8'd185,8'd182,8'd179,
      8'd177,8'd174,8'd171,8'd168,8'd165,8'd162,8'd159,8'd156,
      8'd153,8'd150,8'd147,8'd144,8'd140,8'd137,8'd134,8'd131,
      8'd128,8'd125,8'd122,8'd119,8'd116,8'd112,8'd109,8'd106,
      8'd103,8'd100,8'd97, 8'd94, 8'd91, 8'd88, 8'd85, 8'd82,
      8'd79, 8'd77, 8'd74, 8'd71, 8'd68, 8'd65, 8'd63, 8'd60,
      8'd57, 8'd55, 8'd52, 8'd50, 8'd47, 8'd45, 8'd43, 8'd40,
      8'd38, 8'd36, 8'd34, 8'd32, 8'd30, 8'd28, 8'd26, 8'd24,
      8'd22, 8'd21, 8'd19, 8'd17, 8'd16, 8'd15, 8'd13, 8'd12,
      8'd11, 8'd10, 8'd8,  8'd7,  8'd6,  8'd6,  8'd5,  8'd4,
      8'd3,  8'd3,  8'd2,  8'd2,  8'd2,  8'd1,  8'd1,  8'd1,
      8'd1,  8'd1,  8'd1,  8'd1,  8'd2,  8'd2,  8'd2,  8'd3,
      8'd3,  8'd4,  8'd5,  8'd6,  8'd6,  8'd7,  8'd8,  8'd10,
      8'd11, 8'd12, 8'd13, 8'd15, 8'd16, 8'd17, 8'd19, 8'd21,
      8'd22, 8'd24, 8'd26, 8'd28, 8'd30, 8'd32, 8'd34, 8'd36,
      8'd38, 8'd40, 8'd43, 8'd45, 8'd47, 8'd50, 8'd52, 8'd55,
      8'd57, 8'd60, 8'd63, 8'd65, 8'd68, 8'd71, 8'd74, 8'd77,
      8'd79, 8'd82, 8'd85, 8'd88, 8'd91, 8'd94, 8'd97, 8'd100,
      8'd103,8'd106,8'd109,8'd112,8'd116,8'd119,8'd122,8'd125
   };

   function automatic logic [7:0] sine_at(input logic [7:0] idx);
      return SINE_LUT[idx];
   endfunction

   // level / 37 for an 8-bit level, 0..6
   function automatic logic [2:0] palette_select(input logic [7:0] level);
      logic [2:0] sel;
      sel = 3'd0;
      for (int i = 1; i <= 6; i++) begin
         if (level >= 8'(i * 37)) begin
            sel = 3'(i);
         end
      end
      return sel;
   endfunction

endpackage : spag_pkg

`default_nettype wire

FILE: rtl/spag_phase.sv
// Phase accumulators and drift indices, stepped on each advance request.
// Exposes the phase high bytes to the pixel datapath. Depends on spag_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spag_phase
   import spag_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           advance,
   input  wire logic [1:0]     drift_step_one,
   input  wire logic [1:0]     drift_step_two,
   input  wire logic [1:0]     drift_step_three,
   output phase_view_type      phase_view
);

   logic [15:0] phase_ff [PHASE_COUNT];
   logic [15:0] phase_in [PHASE_COUNT];
   logic [7:0]  drift_ff [PHASE_COUNT];
   logic [7:0]  drift_in [PHASE_COUNT];

   always_comb begin
      for (int k = 0; k < PHASE_COUNT; k++) begin
         phase_in[k] = phase_ff[k]
                     + 16'(PHASE_GAIN[k]) * 16'(sine_at(drift_ff[k]))
                     - (16'(PHASE_GAIN[k]) << 7);
      end
      drift_in[0] = drift_ff[0] + DRIFT_STEP_1A;
      drift_in[1] = drift_ff[1] + 8'(drift_step_one);
      drift_in[2] = drift_ff[2] + DRIFT_STEP_2A;
      drift_in[3] = drift_ff[3] + 8'(drift_step_two);
      drift_in[4] = drift_ff[4] + DRIFT_STEP_3A;
      drift_in[5] = drift_ff[5] + 8'(drift_step_three);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < PHASE_COUNT; k++) begin
         if (reset) begin
            phase_ff[k] <= '0;
            drift_ff[k] <= '0;
         end else if (advance) begin
            phase_ff[k] <= phase_in[k];
            drift_ff[k] <= drift_in[k];
         end
      end
   end

   assign phase_view.p1a = phase_ff[0][15:8];
   assign phase_view.p1b = phase_ff[1][15:8];
   assign phase_view.p2a = phase_ff[2][15:8];
   assign phase_view.p2b = phase_ff[3][15:8];
   assign phase_view.p3a = phase_ff[4][15:8];
   assign phase_view.p3b = phase_ff[5][15:8];

endmodule : spag_phase

`default_nettype wire

FILE: rtl/spag_pixel.sv
// Pixel attribute datapath: eight sine lookups, two layer sums, palette pick.
// Combinational; depends on spag_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spag_pixel
   import spag_pkg::*;
(
   input  wire phase_view_type phase_view,
   input  wire logic [5:0]    row,
   input  wire logic [6:0]    column,
   input  wire logic [5:0]    row_count,
   input  wire logic [27:0]   ink_palette,
   input  wire logic [27:0]   paper_palette,
   output logic [7:0]         attribute
);

   logic [7:0] r8;
   logic [7:0] c8;
   logic [7:0] rc8;
   logic [7:0] idx_y0a, idx_y0b, idx_x0a, idx_x0b;
   logic [7:0] idx_y1a, idx_y1b, idx_x1a, idx_x1b;
   logic [7:0] level_one;
   logic [7:0] level_two;
   logic [2:0] sel_one;
   logic [2:0] sel_two;

   always_comb begin
      r8  = 8'(row);
      c8  = 8'(column);
      rc8 = 8'(row_count);

      // all phase sums are taken modulo 256
      idx_y0a = phase_view.p1a + r8 * 8'd13 + phase_view.p2a;
      idx_y0b = phase_view.p1b - r8 * 8'd5;
      idx_x0a = phase_view.p2a + c8 * 8'd11 + phase_view.p1b - rc8 * 8'd5;
      idx_x0b = phase_view.p2b - c8 * 8'd7;

      idx_y1a = phase_view.p3b - r8 * 8'd6 + phase_view.p2b;
      idx_y1b = phase_view.p1b + r8 * 8'd4;
      idx_x1a = phase_view.p3a - c8 * 8'd9 + phase_view.p1b + rc8 * 8'd4;
      idx_x1b = phase_view.p2b + c8 * 8'd7;

      level_one = sine_at(idx_y0a) + sine_at(idx_y0b)
                + sine_at(idx_x0a) + sine_at(idx_x0b);
      level_two = sine_at(idx_y1a) + sine_at(idx_y1b)
                + sine_at(idx_x1a) + sine_at(idx_x1b);

      sel_one = palette_select(level_one);
      sel_two = palette_select(level_two);

      attribute = {paper_palette[{sel_two, 2'b00} +: 4],
                   ink_palette[{sel_one, 2'b00} +: 4]};
   end

endmodule : spag_pixel

`default_nettype wire

FILE: rtl/sine_plasma_attribute_generator_unit.sv
// Top level of the sine plasma attribute generator: request register,
// result register, config registers. Uses spag_pkg, spag_phase, spag_pixel.
`timescale 1ns / 1ps
`default_nettype none

// Takes one request per clock while req_stall is low. A pixel request
// (kind 0) passes the request register, then the result register puts one
// attribute byte on rsp; an advance request (kind 1) steps the phase and drift
// state and returns nothing. The request register feeds a single pass of sine
// lookups and the palette pick into the result register, and the state is
// stepped as an advance leaves the request register, so every request sees
// all earlier advances. req_stall rises only while a finished result is held
// by rsp_stall and a pixel request waits behind it. Config writes are always
// taken (csr_ready is high) and should be made while the block is idle;
// index 3 is ignored.

module sine_plasma_attribute_generator_unit
   import spag_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,

   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_kind,
   input  wire logic [5:0]                  req_row,
   input  wire logic [6:0]                  req_column,
   input  wire logic [1:0]                  req_drift_step_one,
   input  wire logic [1:0]                  req_drift_step_two,
   input  wire logic [1:0]                  req_drift_step_three,

   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [7:0]                       rsp_attribute,

   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]   csr_data
);

   logic        req_valid_ff;
   logic        req_valid_in;
   logic        kind_ff;
   logic [5:0]  row_ff;
   logic [6:0]  column_ff;
   logic [1:0]  step_one_ff;
   logic [1:0]  step_two_ff;
   logic [1:0]  step_three_ff;

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [7:0]  rsp_attribute_ff;

   logic [5:0]  row_count_ff;
   logic [27:0] ink_palette_ff;
   logic [27:0] paper_palette_ff;

   logic        req_accept;
   logic        out_free;
   logic        stage_move;
   logic        advance;
   logic        pixel_done;
   logic [7:0]  attribute;
   phase_view_type phase_view;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign stage_move = req_valid_ff && (kind_ff == KIND_ADVANCE || out_free);
   assign advance    = stage_move && kind_ff == KIND_ADVANCE;
   assign pixel_done = stage_move && kind_ff == KIND_PIXEL;
   assign req_stall  = req_valid_ff && !stage_move;
   assign req_accept = req_valid && !req_stall;

   assign req_valid_in = req_accept || (req_valid_ff && !stage_move);
   assign rsp_valid_in = pixel_done || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff       <= req_kind;
         row_ff        <= req_row;
         column_ff     <= req_column;
         step_one_ff   <= req_drift_step_one;
         step_two_ff   <= req_drift_step_two;
         step_three_ff <= req_drift_step_three;
      end
      if (pixel_done) begin
         rsp_attribute_ff <= attribute;
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff     <= ROW_COUNT_RESET;
         ink_palette_ff   <= INK_PALETTE_RESET;
         paper_palette_ff <= PAPER_PALETTE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROW_COUNT: begin
               row_count_ff <= csr_data[5:0];
            end
            CSR_INK_PALETTE: begin
               ink_palette_ff <= csr_data;
            end
            CSR_PAPER_PALETTE: begin
               paper_palette_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   spag_phase u_phase (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .drift_step_one   (step_one_ff),
      .drift_step_two   (step_two_ff),
      .drift_step_three (step_three_ff),
      .phase_view       (phase_view)
   );

   spag_pixel u_pixel (
      .phase_view    (phase_view),
      .row           (row_ff),
      .column        (column_ff),
      .row_count     (row_count_ff),
      .ink_palette   (ink_palette_ff),
      .paper_palette (paper_palette_ff),
      .attribute     (attribute)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_attribute = rsp_attribute_ff;

endmodule : sine_plasma_attribute_generator_unit

`default_nettype wire

FILE: rtl/spag_checker.sv
// Port-level checks for sine_plasma_attribute_generator_unit, with its bind.
// Depends on spag_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spag_checker
   import spag_pkg::*;
(
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_stall,
   input wire logic                        req_kind,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire logic [7:0]                  rsp_attribute
);

   // a held result keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_attribute))
      else $error("stalled result changed");

   // reset empties both stages
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not empty after reset");

   // requests back up only behind a held result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stall without held result");

   // an accepted pixel request passes the request and result registers to the output if rsp_stall is then low
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_kind == KIND_PIXEL) ##1 !rsp_stall |=> rsp_valid)
      else $error("pixel result missing");

endmodule : spag_checker

bind sine_plasma_attribute_generator_unit spag_checker u_checker (.*);

`default_nettype wire
